// ===== design/cpc_pkg.sv =====
package cpc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_COL = 2'd0,
        CFG_CENTER_ROW = 2'd1,
        CFG_GAIN       = 2'd2
    } t_cfg_idx;

    localparam int CENTER_COL_RESET = 320;
    localparam int CENTER_ROW_RESET = 240;
    localparam int GAIN_RESET       = 4096;

    // Result field widths
    localparam int RADIUS_W   = 17;
    localparam int ANGLE_W    = 15;
    localparam int CONTRAST_W = 15;
    localparam int GAIN_W     = 16;

    localparam int RADIUS_MAX   = 131071;
    localparam int ANGLE_LIMIT  = 12868;
    localparam int CONTRAST_MAX = 18022;

    // Radius is Q.4, so the square root runs on d2 scaled by 2^8
    localparam int RADIUS_SQ_SHIFT = 8;

    // Contrast limit: 100 * d2 <= 121 * center_col^2
    localparam int CONTRAST_NUM = 121;
    localparam int CONTRAST_DEN = 100;

    // Contrast divider: (radius * 2^11) / center_col, then round by one bit
    localparam int CONTRAST_SHIFT = 11;
    localparam int QUOT_W         = 16;

    // CORDIC angle accumulator, Q2.30 with headroom
    localparam int Z_W         = 34;
    localparam int ATAN_LEN    = 24;
    localparam int COORD_FRAC  = 16;
    localparam int ANGLE_SHIFT = 18;
    localparam int HALF_PI_Q30 = 1686629713;

    // Arctangent of 2^-idx in Q2.30
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(843314856);
            1:       v = Z_W'(497837829);
            2:       v = Z_W'(263043836);
            3:       v = Z_W'(133525158);
            4:       v = Z_W'(67021686);
            5:       v = Z_W'(33543515);
            6:       v = Z_W'(16775850);
            7:       v = Z_W'(8388437);
            8:       v = Z_W'(4194282);
            9:       v = Z_W'(2097149);
            10:      v = Z_W'(1048576);
            11:      v = Z_W'(524288);
            12:      v = Z_W'(262144);
            13:      v = Z_W'(131072);
            14:      v = Z_W'(65536);
            15:      v = Z_W'(32768);
            16:      v = Z_W'(16384);
            17:      v = Z_W'(8192);
            18:      v = Z_W'(4096);
            19:      v = Z_W'(2048);
            20:      v = Z_W'(1024);
            21:      v = Z_W'(512);
            22:      v = Z_W'(256);
            23:      v = Z_W'(128);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/cpc_front.sv =====
module cpc_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COORD_BITS-1:0]   i_pixel_col,
    input  logic [COORD_BITS-1:0]   i_pixel_row,
    input  logic [COORD_BITS-1:0]   i_center_col,
    input  logic [COORD_BITS-1:0]   i_center_row,
    output logic                    o_valid,
    output logic signed [COORD_BITS:0] o_dx,
    output logic signed [COORD_BITS:0] o_dy,
    output logic [2*COORD_BITS:0]   o_d2,
    output logic                    o_cond
);
    import cpc_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int SQW   = 2 * COORD_BITS;
    localparam int D2W   = 2 * COORD_BITS + 1;
    localparam int C121W = 2 * COORD_BITS + 7;
    localparam int D100W = 2 * COORD_BITS + 8;

    logic r_v0, r_v1, r_v2, r_v3;
    logic ld0;

    logic signed [DW-1:0] r_dx0, r_dy0, r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic signed [DW-1:0] n_dx0, n_dy0;
    logic [SQW-1:0]       r_sqx1, r_sqy1, r_ccsq1;
    logic [D2W-1:0]       r_d2_2, r_d2_3;
    logic [C121W-1:0]     r_c121_2;
    logic                 r_ccnz2, r_cond3;

    logic signed [2*DW-1:0] c_px, c_py;
    logic [SQW-1:0]         c_ccsq;

    // First stage takes a new item whenever it is empty or the pipe advances
    assign ld0     = i_en || !r_v0;
    assign o_ready = ld0;

    assign n_dx0 = $signed({1'b0, i_pixel_col}) - $signed({1'b0, i_center_col});
    assign n_dy0 = $signed({1'b0, i_pixel_row}) - $signed({1'b0, i_center_row});

    assign c_px   = r_dx0 * r_dx0;
    assign c_py   = r_dy0 * r_dy0;
    assign c_ccsq = SQW'(i_center_col) * SQW'(i_center_col);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0) begin
                r_v0 <= i_valid;
            end
            if (i_en) begin
                r_v1 <= r_v0;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // Offsets, squares, sum of squares, contrast limit test
    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_dx0 <= n_dx0;
            r_dy0 <= n_dy0;
        end
        if (i_en) begin
            r_dx1    <= r_dx0;
            r_dy1    <= r_dy0;
            r_sqx1   <= c_px[SQW-1:0];
            r_sqy1   <= c_py[SQW-1:0];
            r_ccsq1  <= c_ccsq;

            r_dx2    <= r_dx1;
            r_dy2    <= r_dy1;
            r_d2_2   <= D2W'(r_sqx1) + D2W'(r_sqy1);
            r_c121_2 <= C121W'(r_ccsq1) * C121W'(CONTRAST_NUM);
            r_ccnz2  <= (i_center_col != '0);

            r_dx3    <= r_dx2;
            r_dy3    <= r_dy2;
            r_d2_3   <= r_d2_2;
            r_cond3  <= r_ccnz2 &&
                        ((D100W'(r_d2_2) * D100W'(CONTRAST_DEN)) <= D100W'(r_c121_2));
        end
    end

    assign o_valid = r_v3;
    assign o_dx    = r_dx3;
    assign o_dy    = r_dy3;
    assign o_d2    = r_d2_3;
    assign o_cond  = r_cond3;

endmodule

// ===== design/cpc_cordic.sv =====
module cpc_cordic #(
    parameter int COORD_BITS = 12,
    parameter int STAGES     = 16,
    parameter int SIDE_W     = 26
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [COORD_BITS:0]        i_dx,
    input  logic signed [COORD_BITS:0]        i_dy,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic signed [cpc_pkg::ANGLE_W-1:0] o_angle,
    output logic [SIDE_W-1:0]                 o_side
);
    import cpc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int XW = DW + COORD_FRAC + 3;
    localparam int N  = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

    localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(HALF_PI_Q30);
    localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(1) <<< (ANGLE_SHIFT - 1);
    localparam logic signed [Z_W-1:0] ANG_LIM = Z_W'(ANGLE_LIMIT);

    logic                  r_v    [0:N];
    logic signed [XW-1:0]  r_x    [0:N];
    logic signed [XW-1:0]  r_y    [0:N];
    logic signed [Z_W-1:0] r_z    [0:N];
    logic                  r_zero [0:N];
    logic [SIDE_W-1:0]     r_side [0:N];

    logic signed [DW-1:0]  c_px, c_py;
    logic signed [Z_W-1:0] c_pz;
    logic signed [Z_W-1:0] c_zr, c_zc;

    logic                         r_out_v;
    logic signed [ANGLE_W-1:0]    r_angle;
    logic [SIDE_W-1:0]            r_out_side;

    // Turn the left half plane into the right half plane
    always_comb begin
        if (!i_dx[DW-1]) begin
            c_px = i_dx;
            c_py = i_dy;
            c_pz = '0;
        end else if (!i_dy[DW-1]) begin
            c_px = i_dy;
            c_py = -i_dx;
            c_pz = HALF_PI;
        end else begin
            c_px = -i_dy;
            c_py = i_dx;
            c_pz = -HALF_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= {{3{c_px[DW-1]}}, c_px, {COORD_FRAC{1'b0}}};
            r_y[0]    <= {{3{c_py[DW-1]}}, c_py, {COORD_FRAC{1'b0}}};
            r_z[0]    <= c_pz;
            r_zero[0] <= (i_dx == '0) && (i_dy == '0);
            r_side[0] <= i_side;
        end
    end

    // One micro-rotation per stage, driving y toward zero
    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [Z_W-1:0] ATAN_I = atan_q30(i);
        logic signed [XW-1:0]  c_x, c_y;
        logic signed [Z_W-1:0] c_z;

        always_comb begin
            if (!r_y[i][XW-1]) begin
                c_x = r_x[i] + (r_y[i] >>> i);
                c_y = r_y[i] - (r_x[i] >>> i);
                c_z = r_z[i] + ATAN_I;
            end else begin
                c_x = r_x[i] - (r_y[i] >>> i);
                c_y = r_y[i] + (r_x[i] >>> i);
                c_z = r_z[i] - ATAN_I;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= c_x;
                r_y[i+1]    <= c_y;
                r_z[i+1]    <= c_z;
                r_zero[i+1] <= r_zero[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    // Round Q2.30 to Q3.12 and clamp
    always_comb begin
        c_zr = (r_z[N] + Z_ROUND) >>> ANGLE_SHIFT;
        if (r_zero[N]) begin
            c_zc = '0;
        end else if (c_zr > ANG_LIM) begin
            c_zc = ANG_LIM;
        end else if (c_zr < -ANG_LIM) begin
            c_zc = -ANG_LIM;
        end else begin
            c_zc = c_zr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle    <= c_zc[ANGLE_W-1:0];
            r_out_side <= r_side[N];
        end
    end

    assign o_valid = r_out_v;
    assign o_angle = r_angle;
    assign o_side  = r_out_side;

endmodule

// ===== design/cpc_isqrt.sv =====
module cpc_isqrt #(
    parameter int COORD_BITS = 12,
    parameter int SIDE_W     = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*COORD_BITS:0]   i_d2,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [COORD_BITS+4:0]   o_root,
    output logic [SIDE_W-1:0]       o_side
);
    import cpc_pkg::*;

    localparam int RB = COORD_BITS + 5;
    localparam int RW = 2 * RB + 1;

    // Stage inputs; entry RB feeds the rounding stage
    logic              c_v    [0:RB];
    logic [RW-1:0]     c_rem  [0:RB];
    logic [RB-1:0]     c_root [0:RB];
    logic [SIDE_W-1:0] c_side [0:RB];

    logic              r_v    [0:RB-1];
    logic [RW-1:0]     r_rem  [0:RB-1];
    logic [RB-1:0]     r_root [0:RB-1];
    logic [SIDE_W-1:0] r_side [0:RB-1];

    logic              r_out_v;
    logic [RB-1:0]     r_out_root;
    logic [SIDE_W-1:0] r_out_side;
    logic [RB-1:0]     c_rounded;

    assign c_v[0]    = i_valid;
    assign c_rem[0]  = RW'(i_d2) << RADIUS_SQ_SHIFT;
    assign c_root[0] = '0;
    assign c_side[0] = i_side;

    // One root bit per stage, most significant first
    for (genvar j = 0; j < RB; j++) begin : g_bit
        localparam int K = RB - 1 - j;
        logic [RW-1:0] c_test;
        logic          c_ge;

        assign c_test = (RW'(c_root[j]) << (K + 1)) + (RW'(1) << (2 * K));
        assign c_ge   = (c_rem[j] >= c_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= c_ge ? (c_rem[j] - c_test) : c_rem[j];
                r_root[j] <= c_ge ? (c_root[j] | (RB'(1) << K)) : c_root[j];
                r_side[j] <= c_side[j];
            end
        end

        assign c_v[j+1]    = r_v[j];
        assign c_rem[j+1]  = r_rem[j];
        assign c_root[j+1] = r_root[j];
        assign c_side[j+1] = r_side[j];
    end

    // Round to nearest, halves up: bump when s - r^2 exceeds r
    assign c_rounded = (c_rem[RB] > RW'(c_root[RB])) ? (c_root[RB] + RB'(1)) : c_root[RB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= c_v[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_root <= c_rounded;
            r_out_side <= c_side[RB];
        end
    end

    assign o_valid = r_out_v;
    assign o_root  = r_out_root;
    assign o_side  = r_out_side;

endmodule

// ===== design/cpc_div.sv =====
module cpc_div #(
    parameter int COORD_BITS = 12,
    parameter int SIDE_W     = 33
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [COORD_BITS+4:0]         i_root,
    input  logic [COORD_BITS-1:0]         i_center_col,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [cpc_pkg::QUOT_W-1:0]    o_quot,
    output logic [SIDE_W-1:0]             o_side
);
    import cpc_pkg::*;

    localparam int RB = COORD_BITS + 5;
    localparam int W  = RB + CONTRAST_SHIFT + 1;

    logic              c_v    [0:QUOT_W];
    logic [W-1:0]      c_rem  [0:QUOT_W];
    logic [QUOT_W-1:0] c_q    [0:QUOT_W];
    logic [SIDE_W-1:0] c_side [0:QUOT_W];

    logic              r_v    [0:QUOT_W-1];
    logic [W-1:0]      r_rem  [0:QUOT_W-1];
    logic [QUOT_W-1:0] r_q    [0:QUOT_W-1];
    logic [SIDE_W-1:0] r_side [0:QUOT_W-1];

    assign c_v[0]    = i_valid;
    assign c_rem[0]  = W'(i_root) << CONTRAST_SHIFT;
    assign c_q[0]    = '0;
    assign c_side[0] = i_side;

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUOT_W; j++) begin : g_bit
        localparam int K = QUOT_W - 1 - j;
        logic [W-1:0] c_test;
        logic         c_ge;

        assign c_test = W'(i_center_col) << K;
        assign c_ge   = (c_rem[j] >= c_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= c_ge ? (c_rem[j] - c_test) : c_rem[j];
                r_q[j]    <= c_ge ? (c_q[j] | (QUOT_W'(1) << K)) : c_q[j];
                r_side[j] <= c_side[j];
            end
        end

        assign c_v[j+1]    = r_v[j];
        assign c_rem[j+1]  = r_rem[j];
        assign c_q[j+1]    = r_q[j];
        assign c_side[j+1] = r_side[j];
    end

    assign o_valid = c_v[QUOT_W];
    assign o_quot  = c_q[QUOT_W];
    assign o_side  = c_side[QUOT_W];

endmodule

// ===== design/cue_cartesian_to_polar_core.sv =====
// Cartesian to polar conversion of cue pixel positions about a frame center.
//
// Input channel (i_valid / o_ready) carries one pixel column and row per
// transfer. Output channel (o_valid / i_ready) carries radius (Q13.4), angle
// (Q3.12 radians, atan2 of dy over dx), contrast (radius over center column,
// Q1.14, zero above 1.1) and the configured gain.
//
// Configuration is a plain write port: i_cfg_we with i_cfg_idx selecting
// center column, center row or gain. Write it only while no item is in flight.
//
// The pipe holds 4 front stages, CORDIC_STAGES + 2 CORDIC stages, COORD_BITS + 6
// square root stages, 16 divider stages and the output register. One item per
// cycle is accepted while the receiver keeps i_ready high.
//
// Reset clears all valid bits and loads center 320/240 and gain 1.0. When the
// receiver stalls the whole pipe holds; the first stage still takes an item
// if it is empty, so nothing is lost or repeated.
module cue_cartesian_to_polar_core #(
    parameter int COORD_BITS    = 12,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cpc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [COORD_BITS-1:0]                i_pixel_col,
    input  logic [COORD_BITS-1:0]                i_pixel_row,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [cpc_pkg::RADIUS_W-1:0]         o_radius,
    output logic signed [cpc_pkg::ANGLE_W-1:0]   o_angle,
    output logic [cpc_pkg::CONTRAST_W-1:0]       o_contrast,
    output logic [cpc_pkg::GAIN_W-1:0]           o_gain_out
);
    import cpc_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int D2W   = 2 * COORD_BITS + 1;
    localparam int RB    = COORD_BITS + 5;
    localparam int RXW   = (RB > RADIUS_W) ? RB : RADIUS_W;
    localparam int SIDE1 = D2W + 1;
    localparam int SIDE2 = ANGLE_W + 1;
    localparam int SIDE3 = RB + ANGLE_W + 1;

    logic [COORD_BITS-1:0] r_center_col, r_center_row;
    logic [GAIN_W-1:0]     r_gain;

    logic en;

    logic                  fr_valid, fr_cond;
    logic signed [DW-1:0]  fr_dx, fr_dy;
    logic [D2W-1:0]        fr_d2;

    logic                  co_valid;
    logic signed [ANGLE_W-1:0] co_angle;
    logic [SIDE1-1:0]      co_side;

    logic                  sq_valid;
    logic [RB-1:0]         sq_root;
    logic [SIDE2-1:0]      sq_side;

    logic                  dv_valid;
    logic [QUOT_W-1:0]     dv_quot;
    logic [SIDE3-1:0]      dv_side;

    logic [RB-1:0]         c_root;
    logic [ANGLE_W-1:0]    c_angle;
    logic                  c_cond;
    logic [QUOT_W:0]       c_qinc;
    logic [QUOT_W-1:0]     c_half;
    logic [CONTRAST_W-1:0] c_contrast;
    logic [RADIUS_W-1:0]   c_radius;

    logic                  r_out_v;
    logic [RADIUS_W-1:0]   r_radius;
    logic signed [ANGLE_W-1:0] r_angle;
    logic [CONTRAST_W-1:0] r_contrast;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col <= COORD_BITS'(CENTER_COL_RESET);
            r_center_row <= COORD_BITS'(CENTER_ROW_RESET);
            r_gain       <= GAIN_W'(GAIN_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_COL: r_center_col <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_ROW: r_center_row <= i_cfg_data[COORD_BITS-1:0];
                CFG_GAIN:       r_gain       <= i_cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Whole pipe advances unless the output holds an untaken result
    assign en = !r_out_v || i_ready;

    cpc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_center_col (r_center_col),
        .i_center_row (r_center_row),
        .o_valid      (fr_valid),
        .o_dx         (fr_dx),
        .o_dy         (fr_dy),
        .o_d2         (fr_d2),
        .o_cond       (fr_cond)
    );

    cpc_cordic #(
        .COORD_BITS (COORD_BITS),
        .STAGES     (CORDIC_STAGES),
        .SIDE_W     (SIDE1)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_dx    (fr_dx),
        .i_dy    (fr_dy),
        .i_side  ({fr_cond, fr_d2}),
        .o_valid (co_valid),
        .o_angle (co_angle),
        .o_side  (co_side)
    );

    cpc_isqrt #(
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (SIDE2)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (co_valid),
        .i_d2    (co_side[D2W-1:0]),
        .i_side  ({co_side[D2W], co_angle}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    cpc_div #(
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (SIDE3)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (sq_valid),
        .i_root       (sq_root),
        .i_center_col (r_center_col),
        .i_side       ({sq_root, sq_side}),
        .o_valid      (dv_valid),
        .o_quot       (dv_quot),
        .o_side       (dv_side)
    );

    // Unpack and finish contrast and radius
    assign c_root  = dv_side[SIDE3-1:SIDE2];
    assign c_cond  = dv_side[SIDE2-1];
    assign c_angle = dv_side[ANGLE_W-1:0];
    assign c_qinc  = (QUOT_W + 1)'(dv_quot) + (QUOT_W + 1)'(1);
    assign c_half  = c_qinc[QUOT_W:1];

    always_comb begin
        if (!c_cond) begin
            c_contrast = '0;
        end else if (c_half > QUOT_W'(CONTRAST_MAX)) begin
            c_contrast = CONTRAST_W'(CONTRAST_MAX);
        end else begin
            c_contrast = c_half[CONTRAST_W-1:0];
        end
    end

    assign c_radius = (RXW'(c_root) > RXW'(RADIUS_MAX)) ? RADIUS_W'(RADIUS_MAX)
                                                        : RADIUS_W'(c_root);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_radius   <= c_radius;
            r_angle    <= $signed(c_angle);
            r_contrast <= c_contrast;
        end
    end

    assign o_valid    = r_out_v;
    assign o_radius   = r_radius;
    assign o_angle    = r_angle;
    assign o_contrast = r_contrast;
    assign o_gain_out = r_gain;

endmodule

// ===== design/cpc_checker.sv =====
module cpc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_cfg_we,
    input logic [cpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input logic [cpc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [cpc_pkg::RADIUS_W-1:0]         o_radius,
    input logic signed [cpc_pkg::ANGLE_W-1:0]   o_angle,
    input logic [cpc_pkg::CONTRAST_W-1:0]       o_contrast,
    input logic [cpc_pkg::GAIN_W-1:0]           o_gain_out
);
    import cpc_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_radius) && $stable(o_angle)
                                && $stable(o_contrast))
        else $error("stalled result changed");

    // Zero radius means a zero vector, whose angle is zero
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_radius == '0) |-> (o_angle == '0))
        else $error("zero radius with nonzero angle");

    // Contrast is radius over center column, so it needs a radius
    a_contrast_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_contrast != '0) |-> (o_radius != '0))
        else $error("contrast without radius");

    // Gain write shows on the output next cycle
    a_gain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == CFG_GAIN) |=> (o_gain_out == $past(i_cfg_data)))
        else $error("gain write not reflected");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("pipe not empty after reset");

endmodule

bind cue_cartesian_to_polar_core cpc_checker u_cpc_checker (.*);

// ===== tb/tb_cue_cartesian_to_polar_core.sv =====
`timescale 1ns / 1ps

module tb_cue_cartesian_to_polar_core;
    import cpc_pkg::*;

    localparam int COORD_W     = 12;
    localparam int CORDIC_N    = 16;
    localparam int PIPE_DEPTH  = CORDIC_N + COORD_W + 29;
    localparam int MAX_GAP     = 14;
    localparam int HOLD_CYCLES = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;
    localparam int MAX_REPORTS = 30;
    localparam longint TIME_LIMIT = 64'd5_000_000;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Arctangent of 2^-i, Q2.30
    localparam longint ARCTAN_Q30 [0:CORDIC_N-1] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    typedef struct packed {
        logic [RADIUS_W-1:0]          radius;
        logic signed [ANGLE_W-1:0]    angle;
        logic [CONTRAST_W-1:0]        contrast;
        logic [GAIN_W-1:0]            gain;
    } t_polar;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind             kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [COORD_W-1:0]     col;
        logic [COORD_W-1:0]     row;
        bit                     known;
        t_polar                 want;
    } t_step;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_ready;
    logic [COORD_W-1:0]      i_pixel_col = '0;
    logic [COORD_W-1:0]      i_pixel_row = '0;
    logic                    o_valid;
    logic                    i_ready     = 1'b0;
    logic [RADIUS_W-1:0]     o_radius;
    logic signed [ANGLE_W-1:0] o_angle;
    logic [CONTRAST_W-1:0]   o_contrast;
    logic [GAIN_W-1:0]       o_gain_out;

    // Local copy of the register file
    logic [COORD_W-1:0]      cfg_col  = COORD_W'(CENTER_COL_RESET);
    logic [COORD_W-1:0]      cfg_row  = COORD_W'(CENTER_ROW_RESET);
    logic [GAIN_W-1:0]       cfg_gain = GAIN_W'(GAIN_RESET);

    t_polar pending_polar[$];
    t_step  plan[$];
    bit     quiet_mode = 1'b0;
    int     n_sent     = 0;
    int     n_checked  = 0;
    int     n_writes   = 0;
    int     n_errors   = 0;

    cue_cartesian_to_polar_core #(
        .COORD_BITS    (COORD_W),
        .CORDIC_STAGES (CORDIC_N)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_radius    (o_radius),
        .o_angle     (o_angle),
        .o_contrast  (o_contrast),
        .o_gain_out  (o_gain_out)
    );

    always #5 i_clk = ~i_clk;

    // Polar form of one pixel under the current register settings
    function automatic t_polar polar_of(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        t_polar res;
        longint dx, dy, x, y, z, xn;
        longint unsigned d2, rem, root, probe, cc, contrast;
        dx = longint'(col) - longint'(cfg_col);
        dy = longint'(row) - longint'(cfg_row);
        d2 = longint'(dx * dx + dy * dy);
        cc = longint'(cfg_col);

        // Square root of d2 * 256, digit by digit, then round half up
        rem   = d2 << RADIUS_SQ_SHIFT;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        if (rem > root)
            root++;

        // Contrast is zero beyond 1.1 times the center column
        contrast = 0;
        if (cc != 0 && d2 * CONTRAST_DEN <= CONTRAST_NUM * cc * cc) begin
            contrast = ((root << CONTRAST_SHIFT) / cc + 1) >> 1;
            if (contrast > CONTRAST_MAX)
                contrast = CONTRAST_MAX;
        end
        if (root > RADIUS_MAX)
            root = RADIUS_MAX;

        // CORDIC vectoring, left half plane pre-rotated by a quarter turn
        if (dx == 0 && dy == 0) begin
            z = 0;
        end else begin
            if (dx >= 0) begin
                x = dx;  y = dy;  z = 0;
            end else if (dy >= 0) begin
                x = dy;  y = -dx; z = HALF_PI_Q30;
            end else begin
                x = -dy; y = dx;  z = -longint'(HALF_PI_Q30);
            end
            x = x << COORD_FRAC;
            y = y << COORD_FRAC;
            for (int i = 0; i < CORDIC_N; i++) begin
                if (y >= 0) begin
                    xn = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ARCTAN_Q30[i];
                end else begin
                    xn = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ARCTAN_Q30[i];
                end
                x = xn;
            end
            z = (z + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
            if (z > ANGLE_LIMIT)
                z = ANGLE_LIMIT;
            if (z < -ANGLE_LIMIT)
                z = -ANGLE_LIMIT;
        end

        res.radius   = root[RADIUS_W-1:0];
        res.angle    = z[ANGLE_W-1:0];
        res.contrast = contrast[CONTRAST_W-1:0];
        res.gain     = cfg_gain;
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return v[COORD_W-1:0];
    endfunction

    // Centers lean toward the corners of their range
    function automatic logic [COORD_W-1:0] pick_center();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 12'd1;
            3:       return 12'd2048;
            default: return COORD_W'($urandom_range(1, 4095));
        endcase
    endfunction

    function automatic void add_pixel(int col, int row);
        t_step st;
        st = '{kind: STEP_PIXEL, idx: '0, data: '0, col: COORD_W'(col), row: COORD_W'(row),
               known: 1'b0, want: '0};
        plan.push_back(st);
    endfunction

    function automatic void add_known(int col, int row, int gain);
        t_step st;
        st = '{kind: STEP_PIXEL, idx: '0, data: '0, col: COORD_W'(col), row: COORD_W'(row),
               known: 1'b1, want: '{radius: '0, angle: '0, contrast: '0, gain: GAIN_W'(gain)}};
        plan.push_back(st);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_step st;
        st = '{kind: STEP_WRITE, idx: idx, data: data, col: '0, row: '0,
               known: 1'b0, want: '0};
        plan.push_back(st);
    endfunction

    function automatic void report(string what, longint want, longint got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Offer one pixel after a random gap and hold it until the transfer
    task automatic push_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              bit known, t_polar want);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(posedge i_clk); while (!o_ready);
        pending_polar.push_back(known ? want : polar_of(col, row));
        n_sent++;
    endtask

    // Stop offering and let every result come out
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending_polar.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_writes++;
        case (idx)
            CFG_CENTER_COL: cfg_col  = data[COORD_W-1:0];
            CFG_CENTER_ROW: cfg_row  = data[COORD_W-1:0];
            CFG_GAIN:       cfg_gain = data;
            default: ;
        endcase
    endtask

    // Pick a fresh register setting for one random phase
    task automatic configure();
        logic [COORD_W-1:0] col, row;
        logic [GAIN_W-1:0]  gain;
        logic [CFG_DATA_W-1:0] col_data, row_data;
        col = pick_center();
        row = pick_center();
        case ($urandom_range(0, 3))
            0:       gain = '0;
            1:       gain = '1;
            default: gain = GAIN_W'($urandom);
        endcase
        col_data = {4'($urandom), col};
        row_data = {4'($urandom), row};
        drain_pipe();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_CENTER_COL, col_data);
            write_reg(CFG_CENTER_ROW, row_data);
            write_reg(CFG_GAIN, gain);
        end else begin
            write_reg(CFG_GAIN, gain);
            write_reg(CFG_CENTER_ROW, row_data);
            write_reg(CFG_CENTER_COL, col_data);
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
    endtask

    // Receiver: random stall before each transfer, two long hold-offs
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken == 300 || taken == 1000)
                stall = HOLD_CYCLES;
            else
                stall = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_polar want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_polar.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: result with nothing expected, radius %0d angle %0d",
                             $time, o_radius, o_angle);
            end else begin
                want = pending_polar.pop_front();
                n_checked++;
                if (o_radius !== want.radius)
                    report("radius", want.radius, o_radius);
                if (o_angle !== want.angle)
                    report("angle", $signed(want.angle), $signed(o_angle));
                if (o_contrast !== want.contrast)
                    report("contrast", want.contrast, o_contrast);
                if (o_gain_out !== want.gain)
                    report("gain_out", want.gain, o_gain_out);
            end
        end
    end

    initial begin : stimulus
        int choice, span, dc, dr;
        logic [COORD_W-1:0] col, row;

        // Reset values, corners, axes and the contrast limit at 1.1
        add_known(320, 240, GAIN_RESET);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(4095, 0);
        add_pixel(0, 4095);
        add_pixel(640, 240);
        add_pixel(672, 240);
        add_pixel(673, 240);
        add_pixel(0, 240);
        add_pixel(0, 239);
        add_pixel(320, 0);
        add_pixel(320, 4095);
        add_pixel(321, 241);
        // Zero center column; upper data bits must be dropped
        add_write(CFG_CENTER_COL, 16'hF000);
        add_known(0, 240, GAIN_RESET);
        add_pixel(100, 100);
        // Centers at the top of the coordinate range, full gain
        add_write(CFG_CENTER_COL, 16'h0FFF);
        add_write(CFG_CENTER_ROW, 16'hFFFF);
        add_write(CFG_GAIN, 16'hFFFF);
        add_known(4095, 4095, 16'hFFFF);
        add_pixel(0, 0);
        add_pixel(4094, 4095);
        // Zero gain, then a write to the unused index that must change nothing
        add_write(CFG_GAIN, 16'h0000);
        add_write(CFG_IDX_SPARE, 16'hFFFF);
        add_known(4095, 4095, 0);
        add_pixel(2000, 4095);
        // Centers at the middle of the coordinate range
        add_write(CFG_CENTER_COL, 16'h0800);
        add_write(CFG_CENTER_ROW, 16'h0800);
        add_write(CFG_GAIN, 16'h1000);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(4095, 2048);
        add_pixel(0, 2048);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan
        foreach (plan[k]) begin
            if (plan[k].kind == STEP_WRITE) begin
                drain_pipe();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                push_pixel(plan[k].col, plan[k].row, plan[k].known, plan[k].want);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            configure();
            quiet_mode = (p == 2 || p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                choice = $urandom_range(0, 9);
                span   = int'(cfg_col) * 5 / 4 + 4;
                if (choice <= 3) begin
                    col = COORD_W'($urandom);
                    row = COORD_W'($urandom);
                end else if (choice <= 7) begin
                    dc  = int'($urandom_range(0, 2 * span)) - span;
                    dr  = int'($urandom_range(0, 2 * span)) - span;
                    col = clamp_coord(int'(cfg_col) + dc);
                    row = clamp_coord(int'(cfg_row) + dr);
                end else if (choice == 8) begin
                    col = $urandom_range(0, 1) ? cfg_col : COORD_W'($urandom);
                    row = (col == cfg_col) ? COORD_W'($urandom) : cfg_row;
                end else begin
                    col = clamp_coord(int'(cfg_col) + int'($urandom_range(0, 4)) - 2);
                    row = clamp_coord(int'(cfg_row) + int'($urandom_range(0, 4)) - 2);
                end
                push_pixel(col, row, 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        $display("summary: %0d pixels converted over %0d register writes, %0d results checked",
                 n_sent, n_writes, n_checked);
        $display("summary: corners, axes, zero vector, contrast limit, zero and maximum centers");
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #(TIME_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
